// File: src/ftrm_pkg.sv
package ftrm_pkg;

   // Field and register widths
   localparam int unsigned RPM_BITS  = 15;
   localparam int unsigned PPM_BITS  = 8;
   localparam int unsigned ZTH_BITS  = 24;
   localparam int unsigned CSR_BITS  = 24;
   localparam int unsigned CSR_IDX_BITS = 1;

   // Default of the time counter width
   localparam int unsigned TIME_BITS_DEF = 48;

   // Dividend: pulses * 30,000,000 fits below 2^33 for any 8-bit pulse count
   localparam int unsigned DIVD_BITS = 33;
   localparam logic [DIVD_BITS-1:0] HALF_MIN_US = DIVD_BITS'(30000000);
   localparam logic [RPM_BITS-1:0]  RPM_MAX     = {RPM_BITS{1'b1}};

   // Divider step count (one quotient bit per step)
   localparam int unsigned STEP_CNT_BITS = $clog2(RPM_BITS);
   localparam logic [STEP_CNT_BITS-1:0] STEP_LAST = STEP_CNT_BITS'(RPM_BITS - 1);

   // Register reset values
   localparam logic [PPM_BITS-1:0] PPM_RESET = PPM_BITS'(10);
   localparam logic [ZTH_BITS-1:0] ZTH_RESET = ZTH_BITS'(1000000);

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_PPM = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ZTH = 1'b1;

   // Item codes
   localparam logic ACT_TICK = 1'b0;
   localparam logic ACT_READ = 1'b1;

   // Controller to datapath commands
   typedef struct packed {
      logic tick;     // apply one microsecond tick
      logic load;     // start a speed read
      logic sat_chk;  // quotient overflow check
      logic step;     // one restoring divide step
      logic emit;     // move quotient to the output register
   } ftrm_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic fixed;    // result settled without division
   } ftrm_stat_type;

endpackage

// File: src/ftrm_ctrl.sv
module ftrm_ctrl import ftrm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic          req_action,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output ftrm_cmd_type  cmd,
   input  ftrm_stat_type stat
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_STEP,
      ST_EMIT
   } state_type;

   state_type                state_ff;
   logic [STEP_CNT_BITS-1:0] step_ff;
   logic                     rsp_valid_ff;
   logic                     accept;
   logic                     out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   // Command decode
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.tick = accept && (req_action == ACT_TICK);
            cmd.load = accept && (req_action == ACT_READ);
         end
         ST_CHECK: cmd.sat_chk = 1'b1;
         ST_STEP:  cmd.step    = 1'b1;
         ST_EMIT:  cmd.emit    = out_free;
         default:  cmd = '0;
      endcase
   end

   // State, step count and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop valid when taken, unless a new item moves in on the same edge
         if (rsp_valid_ff && !rsp_stall && !cmd.emit) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept && (req_action == ACT_READ)) begin
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               step_ff  <= '0;
               state_ff <= stat.fixed ? ST_EMIT : ST_STEP;
            end
            ST_STEP: begin
               step_ff <= step_ff + 1'b1;
               if (stat.fixed || (step_ff == STEP_LAST)) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// File: src/ftrm_dpath.sv
module ftrm_dpath import ftrm_pkg::*; #(
   parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  ftrm_cmd_type        cmd,
   output ftrm_stat_type       stat,
   input  logic                req_tach_level,
   input  logic [PPM_BITS-1:0] ppm,
   input  logic [ZTH_BITS-1:0] zth,
   output logic [RPM_BITS-1:0] rsp_rpm
);

   localparam int unsigned DW = TIME_BITS + RPM_BITS;

   logic                 prev_level_ff;
   logic [PPM_BITS-1:0]  edge_count_ff;
   logic [TIME_BITS-1:0] time_now_ff;
   logic [TIME_BITS-1:0] last_ff;
   logic [TIME_BITS-1:0] earlier_ff;

   logic [DIVD_BITS-1:0] rem_ff;
   logic [DW-1:0]        div_ff;
   logic [RPM_BITS-1:0]  quo_ff;
   logic                 fixed_ff;
   logic [RPM_BITS-1:0]  rpm_ff;

   logic [TIME_BITS-1:0] time_inc;
   logic [PPM_BITS-1:0]  count_inc;
   logic                 fall;
   logic [TIME_BITS-1:0] since;
   logic [TIME_BITS-1:0] interval;
   logic                 stale;
   logic [DW-1:0]        rem_ext;
   logic                 rem_ge;

   // Tick arithmetic
   assign time_inc  = time_now_ff + 1'b1;
   assign count_inc = edge_count_ff + 1'b1;
   assign fall      = prev_level_ff && !req_tach_level;

   // Read set-up arithmetic
   assign since    = time_now_ff - last_ff;
   assign interval = last_ff - earlier_ff;
   assign stale    = since > TIME_BITS'(zth);

   // Divider compare
   assign rem_ext = DW'(rem_ff);
   assign rem_ge  = rem_ext >= div_ff;

   assign stat.fixed = fixed_ff;
   assign rsp_rpm    = rpm_ff;

   // Time counter, edge count and latch times
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff <= 1'b0;
         edge_count_ff <= '0;
         time_now_ff   <= '0;
         last_ff       <= '0;
         earlier_ff    <= '0;
      end else if (cmd.tick) begin
         time_now_ff   <= time_inc;
         prev_level_ff <= req_tach_level;
         if (fall) begin
            if (count_inc >= ppm) begin
               earlier_ff    <= last_ff;
               last_ff       <= time_inc;
               edge_count_ff <= '0;
            end else begin
               edge_count_ff <= count_inc;
            end
         end
      end
   end

   // Settled-result flag
   always_ff @(posedge clock) begin
      if (reset) begin
         fixed_ff <= 1'b0;
      end else if (cmd.load) begin
         fixed_ff <= stale || (interval == '0);
      end else if (cmd.sat_chk && rem_ge) begin
         fixed_ff <= 1'b1;
      end
   end

   // Restoring divider: divisor starts at interval << 15 and shifts right
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rem_ff <= DIVD_BITS'(ppm) * HALF_MIN_US;
         div_ff <= {interval, RPM_BITS'(0)};
         quo_ff <= stale ? RPM_BITS'(0) : RPM_MAX;
      end else if (cmd.sat_chk) begin
         div_ff <= div_ff >> 1;
         if (!fixed_ff && !rem_ge) begin
            quo_ff <= '0;
         end
      end else if (cmd.step && !fixed_ff) begin
         div_ff <= div_ff >> 1;
         if (rem_ge) begin
            rem_ff <= rem_ff - div_ff[DIVD_BITS-1:0];
            quo_ff <= {quo_ff[RPM_BITS-2:0], 1'b1};
         end else begin
            quo_ff <= {quo_ff[RPM_BITS-2:0], 1'b0};
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rpm_ff <= quo_ff;
      end
   end

endmodule

// File: src/fan_tach_rpm_meter.sv
// Channel   Handshake                Payload
// req_      req_valid / req_stall    req_action, req_tach_level
// rsp_      rsp_valid / rsp_stall    rsp_rpm
// csr_      csr_valid / csr_ready    csr_index, csr_wdata
//
// A tick item gives no result; the block stays idle and can take the next item.
// A read item runs through load, overflow check, up to 15 divide
// steps in the restoring divider (one quotient bit each), then the output load.
// Synchronous active-high reset clears counters and latch times and sets the registers to their reset values.
// A result waiting under rsp_stall does not block ticks; a following read
// holds in its output load until the output register is free.
module fan_tach_rpm_meter import ftrm_pkg::*; #(
   parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_action,
   input  logic                    req_tach_level,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [RPM_BITS-1:0]     rsp_rpm,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CSR_BITS-1:0]     csr_wdata
);

   logic [PPM_BITS-1:0] ppm_ff;
   logic [ZTH_BITS-1:0] zth_ff;
   ftrm_cmd_type        cmd;
   ftrm_stat_type       stat;

   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ppm_ff <= PPM_RESET;
         zth_ff <= ZTH_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PPM: ppm_ff <= csr_wdata[PPM_BITS-1:0];
            CSR_ZTH: zth_ff <= csr_wdata[ZTH_BITS-1:0];
            default: ;
         endcase
      end
   end

   ftrm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .stat       (stat)
   );

   ftrm_dpath #(
      .TIME_BITS (TIME_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_tach_level (req_tach_level),
      .ppm            (ppm_ff),
      .zth            (zth_ff),
      .rsp_rpm        (rsp_rpm)
   );

endmodule

// File: dv/tb_top.sv
module tb_top;
   import ftrm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned        STAMP_BITS     = TIME_BITS_DEF;
   localparam logic [63:0]        HALF_MINUTE_US = 64'd30000000;
   localparam logic [ZTH_BITS-1:0] ZTH_MAX       = {ZTH_BITS{1'b1}};
   localparam int                 DRAIN_CYCLES   = 24;
   localparam int                 WATCHDOG_LIMIT = 2000;
   localparam int                 HOLD_OFF_CYCLES = 400;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_action = ACT_TICK;
   logic                    req_tach_level = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [RPM_BITS-1:0]     rsp_rpm;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = CSR_PPM;
   logic [CSR_BITS-1:0]     csr_wdata = '0;

   // Predicted meter state and its registers
   logic [STAMP_BITS-1:0]   now_us = '0;
   logic [STAMP_BITS-1:0]   latch_us = '0;
   logic [STAMP_BITS-1:0]   prior_latch_us = '0;
   logic [7:0]              pulse_cnt = '0;
   logic                    tach_prev = 1'b0;
   logic [PPM_BITS-1:0]     cfg_ppm = PPM_RESET;
   logic [ZTH_BITS-1:0]     cfg_zth = ZTH_RESET;

   // Speeds owed by accepted reads, oldest first
   logic [RPM_BITS-1:0]     rpm_due[$];

   // Sender burst shaping and receiver stall pattern
   int gap_max = 0;
   int burst_left = 0;
   int stall_pct = 0;
   int stall_run = 0;
   logic stall_on = 1'b0;
   int hold_req = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   int err_count = 0;
   int n_ticks = 0;
   int n_reads = 0;
   int n_results = 0;
   int n_writes = 0;

   fan_tach_rpm_meter DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_tach_level (req_tach_level),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_rpm        (rsp_rpm),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Speed as a read would see it now
   function automatic logic [RPM_BITS-1:0] fan_speed();
      logic [STAMP_BITS-1:0] age;
      logic [STAMP_BITS-1:0] span;
      logic [63:0]           quo;
      age = now_us - latch_us;
      if (age > cfg_zth)
         return '0;
      span = prior_latch_us == latch_us ? '0 : latch_us - prior_latch_us;
      if (span == '0)
         return RPM_MAX;
      quo = (64'(cfg_ppm) * HALF_MINUTE_US) / 64'(span);
      return quo > 64'(RPM_MAX) ? RPM_MAX : quo[RPM_BITS-1:0];
   endfunction

   task automatic report_mismatch(input string what, input logic [RPM_BITS-1:0] got,
                                  input logic [RPM_BITS-1:0] want);
      $display("mismatch at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
      err_count++;
   endtask

   // Offer one item, wait for it to be taken, then update the prediction
   task automatic send_item(input logic act, input logic lvl);
      int gap;
      if (gap_max != 0) begin
         if (burst_left == 0) begin
            gap = $urandom_range(gap_max, 1);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
            burst_left = $urandom_range(24, 1);
         end
         burst_left--;
      end
      req_valid      <= 1'b1;
      req_action     <= act;
      req_tach_level <= lvl;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (act == ACT_READ) begin
         rpm_due.push_back(fan_speed());
         n_reads++;
      end else begin
         // time moves first, so a latch on this tick stores the new time
         now_us = now_us + 1'b1;
         if (tach_prev && !lvl) begin
            pulse_cnt = pulse_cnt + 1'b1;
            if (pulse_cnt >= cfg_ppm) begin
               prior_latch_us = latch_us;
               latch_us       = now_us;
               pulse_cnt      = '0;
            end
         end
         tach_prev = lvl;
         n_ticks++;
      end
   endtask

   // Run of ticks at one level with reads sprinkled in
   task automatic tick_run(input logic lvl, input int count, input int read_pct);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < read_pct)
            send_item(ACT_READ, 1'($urandom));
         send_item(ACT_TICK, lvl);
      end
   endtask

   // Drain all owed results and let a trailing item finish
   task automatic settle();
      req_valid <= 1'b0;
      while (rpm_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx, input logic [CSR_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_PPM)
         cfg_ppm = val[PPM_BITS-1:0];
      else
         cfg_zth = val[ZTH_BITS-1:0];
      n_writes++;
   endtask

   task automatic set_config(input logic [PPM_BITS-1:0] ppm, input logic [ZTH_BITS-1:0] zth);
      settle();
      // junk in the unused upper bits of the pulse register
      write_reg(CSR_PPM, {16'($urandom), ppm});
      write_reg(CSR_ZTH, zth);
   endtask

   // Reads straight out of reset see a zero interval
   task automatic test_reset_state();
      gap_max = 0;
      send_item(ACT_READ, 1'b0);
      send_item(ACT_READ, 1'b1);
   endtask

   // Latch, stale measurement, zero pulse count, large pulse count
   task automatic test_edge_cases();
      set_config(8'd1, '0);
      send_item(ACT_TICK, 1'b1);
      send_item(ACT_TICK, 1'b0);
      send_item(ACT_READ, 1'b0);
      send_item(ACT_TICK, 1'b0);
      send_item(ACT_READ, 1'b1);
      set_config(8'd0, ZTH_MAX);
      send_item(ACT_TICK, 1'b1);
      send_item(ACT_TICK, 1'b0);
      send_item(ACT_READ, 1'b0);
      send_item(ACT_TICK, 1'b1);
      send_item(ACT_TICK, 1'b1);
      send_item(ACT_TICK, 1'b0);
      send_item(ACT_READ, 1'b1);
      set_config(8'd255, ZTH_MAX);
      send_item(ACT_TICK, 1'b1);
      send_item(ACT_TICK, 1'b0);
      send_item(ACT_READ, 1'b0);
   endtask

   // Long tach period so the divider gives an unsaturated speed
   task automatic test_slow_fan();
      int period;
      int high_part;
      set_config(8'd1, ZTH_BITS'($urandom_range(1600, 800)));
      gap_max   = 6;
      stall_pct <= 25;
      // equal high parts, so each interval is the length of the period before
      high_part = $urandom_range(60, 20);
      for (int p = 0; p < 2; p++) begin
         period = p == 0 ? $urandom_range(1000, 920) : high_part + 2;
         tick_run(1'b1, high_part, 3);
         send_item(ACT_TICK, 1'b0);
         send_item(ACT_READ, 1'b0);
         tick_run(1'b0, period - high_part - 1, 3);
      end
   endtask

   // Random settings, square waves with noise, random reads
   task automatic test_random_mix();
      logic [PPM_BITS-1:0] ppm;
      logic [ZTH_BITS-1:0] zth;
      int   half_hi;
      int   wave_left;
      logic wave_lvl;
      int   r;
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               ppm = 8'd1;
               zth = '0;
            end
            1: begin
               ppm = 8'd255;
               zth = ZTH_MAX;
            end
            2: begin
               ppm = PPM_BITS'($urandom_range(4, 1));
               zth = ZTH_BITS'($urandom_range(200));
            end
            3: begin
               ppm = '0;
               zth = ZTH_BITS'($urandom_range(60));
            end
            default: begin
               ppm = PPM_BITS'($urandom_range(255, 1));
               zth = ZTH_BITS'($urandom);
            end
         endcase
         set_config(ppm, zth);
         half_hi   = ppm > 8'd32 ? 2 : $urandom_range(40, 1);
         gap_max   = ph % 2 ? 0 : $urandom_range(8, 1);
         stall_pct <= (ph * 15) % 75;
         wave_left = 0;
         wave_lvl  = 1'($urandom);
         for (int i = 0; i < 135; i++) begin
            r = $urandom_range(99);
            if (r < 15) begin
               send_item(ACT_READ, 1'($urandom));
            end else if (r < 23) begin
               send_item(ACT_TICK, 1'($urandom));
            end else begin
               if (wave_left == 0) begin
                  wave_lvl  = !wave_lvl;
                  wave_left = $urandom_range(half_hi, 1);
               end
               wave_left--;
               send_item(ACT_TICK, wave_lvl);
            end
         end
      end
   endtask

   // Receiver holds off while reads keep coming, so the input stalls
   task automatic test_output_backpressure();
      set_config(8'd3, ZTH_MAX);
      gap_max   = 0;
      stall_pct <= 0;
      hold_req  <= HOLD_OFF_CYCLES;
      for (int i = 0; i < 60; i++) begin
         if (i % 4 == 1)
            send_item(ACT_READ, 1'($urandom));
         else
            send_item(ACT_TICK, (i / 2) % 2 == 0);
      end
      stall_pct <= 40;
      tick_run(1'b1, 20, 30);
   endtask

   // Result checker and receiver stall pattern
   always @(posedge clock) begin
      logic [RPM_BITS-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_results++;
         if (rpm_due.size() == 0) begin
            report_mismatch("result with no read pending", rsp_rpm, '0);
         end else begin
            want = rpm_due.pop_front();
            if (rsp_rpm !== want)
               report_mismatch("rpm", rsp_rpm, want);
         end
      end
      if (hold_req != 0) begin
         hold_left = hold_req;
         hold_req  <= 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (stall_run == 0) begin
            stall_run = $urandom_range(12, 1);
            stall_on  = $urandom_range(99) < stall_pct;
         end
         stall_run--;
         rsp_stall <= stall_on;
      end
   end

   // Watchdog: too long with nothing accepted on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_edge_cases();
      test_slow_fan();
      test_random_mix();
      test_output_backpressure();
      settle();
      $display("covered %0d ticks and %0d speed reads, %0d results checked",
               n_ticks, n_reads, n_results);
      $display("%0d register writes, pulse counts 0/1/3/255 and random, thresholds 0 to max",
               n_writes);
      if (err_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
